FILE: hdl/wes_pkg.sv
`default_nettype none

package wes_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_EVENTS_DEF  = 1024;
  localparam int WEIGHT_BITS_DEF = 32;

  // Fixed field widths of the channels
  localparam int INDEX_BITS     = 10;
  localparam int WEIGHT_IN_BITS = 32;
  localparam int FRAC_BITS      = 32;
  localparam int TOTAL_BITS     = 42;
  localparam int ACTIVE_BITS    = 11;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SELECT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      command;
    logic [INDEX_BITS-1:0]     entry_index;
    logic [WEIGHT_IN_BITS-1:0] weight;
    logic [FRAC_BITS-1:0]      random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] chosen_index;
    logic                  found;
    logic [TOTAL_BITS-1:0] total_weight;
  } out_item_t;

  // Request to and response from the scaled target unit
  typedef struct packed {
    logic                  start;
    logic [FRAC_BITS-1:0]  frac;
    logic [TOTAL_BITS-1:0] total;
  } tgt_req_t;

  typedef struct packed {
    logic                  done;
    logic [TOTAL_BITS-1:0] target;
  } tgt_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/wes_ram.sv
`default_nettype none

module wes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/wes_target.sv
`default_nettype none

// floor(u * total / 2^32) in two registered steps: low product, then high product plus carry-in
module wes_target
  import wes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tgt_req_t req,
  output tgt_rsp_t      rsp
);

  localparam int HI_BITS = TOTAL_BITS - FRAC_BITS;

  logic                    stage1_r;
  logic                    done_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic [HI_BITS-1:0]      hi_r;
  logic [2*FRAC_BITS-1:0]  prod_r;
  logic [TOTAL_BITS-1:0]   target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage1_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      stage1_r <= req.start;
      done_r   <= stage1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      frac_r <= req.frac;
      hi_r   <= req.total[TOTAL_BITS-1:FRAC_BITS];
      prod_r <= (2*FRAC_BITS)'(req.frac) * (2*FRAC_BITS)'(req.total[FRAC_BITS-1:0]);
    end
    if (stage1_r) begin
      target_r <= TOTAL_BITS'(TOTAL_BITS'(frac_r) * TOTAL_BITS'(hi_r))
                + TOTAL_BITS'(prod_r[2*FRAC_BITS-1:FRAC_BITS]);
    end
  end

  assign rsp.done   = done_r;
  assign rsp.target = target_r;

endmodule

`default_nettype wire

FILE: hdl/weighted_event_selector_unit.sv
`default_nettype none

// Roulette-wheel event selector.
// Input channel: drive in_item and raise start; the item is taken at a rising edge
// where start is high and busy is low. Command write replaces the weight of one
// entry and adjusts the running total; command select picks the first active entry
// whose prefix sum exceeds floor(u * total).
// Result channel: one result per item, shown on out_item for one cycle with
// out_valid high. The receiver cannot stall; each result must be taken as it comes.
// Configuration: cfg_we with cfg_wdata sets active_count; write it while idle.
// Sequence: a write passes through S_WRITE before its result; a write beyond the table
// or a select with zero total answers straight from idle. A select waits in S_TARGET
// while the multiplier unit forms the target, then reads one weight per cycle from the
// single RAM read port: a hit ends the scan at the first entry whose prefix exceeds
// the target, a miss after active_count entries (at most MAX_EVENTS), or with no read
// when no entry is active.
// Items are handled one at a time; busy stays high until the result is out.
// Reset: after rst_n the weight RAM is swept to zero, one entry per cycle, over all
// MAX_EVENTS entries with busy high; configuration writes are taken meanwhile.
module weighted_event_selector_unit
  import wes_pkg::*;
#(
  parameter int MAX_EVENTS  = MAX_EVENTS_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire in_item_t               in_item,
  output logic                        out_valid,
  output out_item_t                   out_item,
  input  wire logic                   cfg_we,
  input  wire logic [ACTIVE_BITS-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_EVENTS);
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int CMP_W = (CNT_W > ACTIVE_BITS) ? CNT_W : ACTIVE_BITS;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WRITE  = 5'b00100,
    S_TARGET = 5'b01000,
    S_SCAN   = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  in_item_t                 item_r, item_nxt;
  logic [ACTIVE_BITS-1:0]   active_count_r;
  logic [TOTAL_BITS-1:0]    total_r, total_nxt;
  logic [CNT_W-1:0]         limit_r, limit_nxt;
  logic [CNT_W-1:0]         issue_cnt_r, issue_cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [IDX_W-1:0]         data_idx_r, data_idx_nxt;
  logic [TOTAL_BITS-1:0]    prefix_r, prefix_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [WEIGHT_BITS-1:0]   ram_wdata;
  logic [IDX_W-1:0]         ram_raddr;
  logic [WEIGHT_BITS-1:0]   ram_rdata;

  tgt_req_t                 tgt_req;
  tgt_rsp_t                 tgt_rsp;

  logic                     accept;
  logic                     idx_in_range;
  logic                     issue;
  logic [TOTAL_BITS-1:0]    prefix_sum;
  logic [CMP_W-1:0]         active_ext;

  wes_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_EVENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wes_target u_target (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tgt_req),
    .rsp   (tgt_rsp)
  );

  assign busy         = (state_r != S_IDLE);
  assign accept       = start && !busy;
  assign idx_in_range = (int'(in_item.entry_index) < MAX_EVENTS);
  assign active_ext   = CMP_W'(active_count_r);
  assign issue        = (issue_cnt_r < limit_r);
  assign prefix_sum   = prefix_r + TOTAL_BITS'(ram_rdata);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    total_nxt     = total_r;
    limit_nxt     = limit_r;
    issue_cnt_nxt = issue_cnt_r;
    pend_nxt      = pend_r;
    data_idx_nxt  = data_idx_r;
    prefix_nxt    = prefix_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = '0;
    ram_raddr     = '0;

    tgt_req.start = 1'b0;
    tgt_req.frac  = in_item.random_fraction;
    tgt_req.total = total_r;

    unique case (state_r)
      S_CLEAR: begin
        // sweep zeros through the weight RAM
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(MAX_EVENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // read the old weight now so it is ready in S_WRITE
        ram_raddr = IDX_W'(in_item.entry_index);
        if (accept) begin
          item_nxt = in_item;
          out_item_nxt.chosen_index = '0;
          out_item_nxt.found        = 1'b0;
          out_item_nxt.total_weight = total_r;
          if (in_item.command == CMD_WRITE) begin
            if (idx_in_range) begin
              state_nxt = S_WRITE;
            end else begin
              // drop the write, report the unchanged total
              out_valid_nxt = 1'b1;
            end
          end else if (total_r == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            tgt_req.start = 1'b1;
            if (active_ext > CMP_W'(MAX_EVENTS)) begin
              limit_nxt = CNT_W'(MAX_EVENTS);
            end else begin
              limit_nxt = CNT_W'(active_count_r);
            end
            state_nxt = S_TARGET;
          end
        end
      end

      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(item_r.entry_index);
        ram_wdata = WEIGHT_BITS'(item_r.weight);
        total_nxt = total_r - TOTAL_BITS'(ram_rdata)
                  + TOTAL_BITS'(WEIGHT_BITS'(item_r.weight));
        out_valid_nxt             = 1'b1;
        out_item_nxt.chosen_index = '0;
        out_item_nxt.found        = 1'b0;
        out_item_nxt.total_weight = total_nxt;
        state_nxt                 = S_IDLE;
      end

      S_TARGET: begin
        // hold until the target is formed, then start the scan from entry zero
        issue_cnt_nxt = '0;
        pend_nxt      = 1'b0;
        prefix_nxt    = '0;
        if (tgt_rsp.done) begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        ram_raddr = issue_cnt_r[IDX_W-1:0];
        if (issue) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          data_idx_nxt  = issue_cnt_r[IDX_W-1:0];
        end
        pend_nxt = issue;
        if (pend_r) begin
          if (prefix_sum > tgt_rsp.target) begin
            out_valid_nxt             = 1'b1;
            out_item_nxt.chosen_index = INDEX_BITS'(data_idx_r);
            out_item_nxt.found        = 1'b1;
            pend_nxt                  = 1'b0;
            state_nxt                 = S_IDLE;
          end else begin
            prefix_nxt = prefix_sum;
          end
        end else if (!issue) begin
          // scan ran off the active range without a hit
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      active_count_r <= '0;
      total_r        <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      total_r     <= total_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        active_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    limit_r     <= limit_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    data_idx_r  <= data_idx_nxt;
    prefix_r    <= prefix_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // reset always leads into the clearing sweep
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // an accepted item either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted item dropped");

  // a hit needs a non-zero total and an index inside the table
  a_found_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |->
      (out_item.total_weight != '0 && int'(out_item.chosen_index) < MAX_EVENTS))
    else $error("found result inconsistent");

  // no RAM write may land while the scan reads the weights
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != S_SCAN && state_r != S_TARGET))
    else $error("weight RAM written during select");

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
  import wes_pkg::*;

  localparam int TABLE_DEPTH = MAX_EVENTS_DEF;

  // Clock, reset and the ports of the selector
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  in_item_t               in_item   = '0;
  logic                   cfg_we    = 1'b0;
  logic [ACTIVE_BITS-1:0] cfg_wdata = '0;
  logic                   busy;
  logic                   out_valid;
  out_item_t              out_item;

  // Shadow copy of the event table, its running total and the active count
  logic [WEIGHT_IN_BITS-1:0] weight_mem [TABLE_DEPTH];
  logic [TOTAL_BITS-1:0]     sum_weights;
  logic [ACTIVE_BITS-1:0]    active_entries;

  // Outcomes waiting for the result port, oldest first
  out_item_t   pending_outcomes [$];
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned writes_sent;
  int unsigned selects_sent;
  int unsigned hits_seen;
  int unsigned results_checked;
  int unsigned mismatches;

  weighted_event_selector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Work out what one item does to the table and what it reports.
  // A select compares each prefix against floor(u * total), u being Q0.32,
  // so the product is formed at full width and the fraction bits dropped.
  task automatic roulette_outcome(input in_item_t it, output out_item_t res);
    logic [73:0]           product;
    logic [TOTAL_BITS-1:0] target;
    logic [TOTAL_BITS:0]   prefix;
    int unsigned           scan_len;
    res = '0;
    if (it.command == CMD_WRITE) begin
      sum_weights = sum_weights - TOTAL_BITS'(weight_mem[it.entry_index])
                    + TOTAL_BITS'(it.weight);
      weight_mem[it.entry_index] = it.weight;
    end else if (sum_weights != '0) begin
      product  = 74'(it.random_fraction) * 74'(sum_weights);
      target   = product[73:32];
      // an active count beyond the table behaves as the whole table
      scan_len = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
      prefix   = '0;
      for (int i = 0; i < scan_len && !res.found; i++) begin
        prefix = prefix + (TOTAL_BITS + 1)'(weight_mem[i]);
        if (prefix > (TOTAL_BITS + 1)'(target)) begin
          res.found        = 1'b1;
          res.chosen_index = INDEX_BITS'(i);
        end
      end
    end
    res.total_weight = sum_weights;
  endtask

  // Offer one item, hold it until the selector takes it, then log its outcome.
  // start is left high after acceptance so that back-to-back items need no
  // second assignment in the same step; drop it with the drain task.
  task automatic send_item(input in_item_t it);
    out_item_t res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    roulette_outcome(it, res);
    pending_outcomes.insert(pending_outcomes.size(), res);
    items_sent++;
    if (it.command == CMD_WRITE) begin
      writes_sent++;
    end else begin
      selects_sent++;
      if (res.found) begin
        hits_seen++;
      end
    end
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the active count; call only while nothing is in flight.
  task automatic write_active(input logic [ACTIVE_BITS-1:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_entries = count;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(input cmd_t cmd, input int unsigned idx,
                                         input logic [31:0] w, input logic [31:0] u);
    in_item_t it;
    it.command         = cmd;
    it.entry_index     = INDEX_BITS'(idx);
    it.weight          = w;
    it.random_fraction = u;
    return it;
  endfunction

  // Half writes, half selects. Writes mostly land on active entries so that
  // selects have something to find; weights mix zero, full scale, small and
  // arbitrary values so that both tiny and dominant entries appear.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned span;
    it.entry_index     = INDEX_BITS'($urandom_range(TABLE_DEPTH - 1));
    it.weight          = $urandom;
    it.random_fraction = $urandom;
    span = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
    if ($urandom_range(1) == 1) begin
      it.command = CMD_SELECT;
      case ($urandom_range(9))
        0: it.random_fraction = '0;
        1: it.random_fraction = '1;
        default: ;
      endcase
    end else begin
      it.command = CMD_WRITE;
      if (span != 0 && $urandom_range(4) != 0) begin
        it.entry_index = INDEX_BITS'($urandom_range(span - 1));
      end
      case ($urandom_range(9))
        0: it.weight = '0;
        1: it.weight = '1;
        2, 3, 4, 5: it.weight = $urandom_range(1000);
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_random_burst(input int unsigned count);
    for (int n = 0; n < count; n++) begin
      // now and then let everything drain before the next item
      if ($urandom_range(29) == 0) begin
        wait_drained();
      end
      send_item(random_item());
    end
    wait_drained();
  endtask

  // Table edges, zero total, empty and oversized active counts, weights in
  // inactive entries and the strict prefix-above-target boundary.
  task automatic test_directed_cases();
    idle_pct = 0;
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'hFFFF_FFFF));   // zero total
    send_item(make_item(CMD_WRITE, 0, 32'hFFFF_FFFF, 32'h0));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h0));           // nothing active
    wait_drained();
    write_active(ACTIVE_BITS'(1));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h0));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_item(CMD_WRITE, TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'h0));
    // the inactive entry carries half the total, so a high draw misses
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h7FFF_FFFF));
    wait_drained();
    write_active('1);
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'hFFFF_FFFF));
    send_item(make_item(CMD_WRITE, 0, 32'h0, 32'h0));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h0));           // full scan
    send_item(make_item(CMD_WRITE, 512, 32'h1, 32'h0));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h0));
    send_item(make_item(CMD_WRITE, TABLE_DEPTH - 1, 32'h0, 32'h0));
    send_item(make_item(CMD_WRITE, 512, 32'h0, 32'h0));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h8000_0000));   // back to zero
    wait_drained();
    write_active(ACTIVE_BITS'(TABLE_DEPTH));
    // two equal weights and u one half: the prefix at the first of them equals the target
    send_item(make_item(CMD_WRITE, 1, 32'h1, 32'h0));
    send_item(make_item(CMD_WRITE, 2, 32'h1, 32'h0));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h8000_0000));
    send_item(make_item(CMD_WRITE, 10'h155, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(make_item(CMD_WRITE, 10'h2AA, 32'hAAAA_AAAA, 32'h5555_5555));
    send_item(make_item(CMD_SELECT, 10'h2AA, 32'h5555_5555, 32'h8000_0000));
    send_item(make_item(CMD_SELECT, 10'h155, 32'hAAAA_AAAA, 32'hFFFF_FFFF));
    send_item(make_item(CMD_SELECT, 0, 32'h0, 32'h0));
    wait_drained();
  endtask

  task automatic test_small_table_back_to_back();
    write_active(ACTIVE_BITS'(16));
    idle_pct = 0;
    send_random_burst(150);
  endtask

  task automatic test_sender_gaps();
    write_active(ACTIVE_BITS'(64));
    idle_pct = 73;
    send_random_burst(150);
  endtask

  task automatic test_mixed_gaps();
    write_active(ACTIVE_BITS'($urandom_range(300, 2)));
    idle_pct = 31;
    send_random_burst(150);
  endtask

  // Long scans: keep the count of items down since a miss walks the table.
  task automatic test_full_table();
    write_active(ACTIVE_BITS'(TABLE_DEPTH));
    idle_pct = 31;
    send_random_burst(80);
  endtask

  task automatic test_oversized_count();
    write_active(ACTIVE_BITS'($urandom_range(2047, TABLE_DEPTH + 1)));
    idle_pct = 0;
    send_random_burst(50);
  endtask

  // Every result strobe is taken as it comes; compare it with the oldest
  // outstanding outcome.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: index %0d found %0b total %0d",
                   out_item.chosen_index, out_item.found, out_item.total_weight);
        end
      end else begin
        want = pending_outcomes.pop_front();
        results_checked++;
        if (out_item.chosen_index !== want.chosen_index || out_item.found !== want.found ||
            out_item.total_weight !== want.total_weight) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected index %0d found %0b total %0d", results_checked,
                     want.chosen_index, want.found, want.total_weight);
            $display("result %0d:      got index %0d found %0b total %0d", results_checked,
                     out_item.chosen_index, out_item.found, out_item.total_weight);
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      weight_mem[i] = '0;
    end
    sum_weights     = '0;
    active_entries  = '0;
    idle_pct        = 0;
    items_sent      = 0;
    writes_sent     = 0;
    selects_sent    = 0;
    hits_seen       = 0;
    results_checked = 0;
    mismatches      = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // the count is taken during the clearing sweep as well
    write_active('0);
    test_directed_cases();
    test_small_table_back_to_back();
    test_sender_gaps();
    test_mixed_gaps();
    test_full_table();
    test_oversized_count();
    // allow a full scan's worth of cycles for any stray result
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    $display("covered %0d items: %0d writes, %0d selects (%0d hits), active counts 0 to 2047",
             items_sent, writes_sent, selects_sent, hits_seen);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(20 * 3_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/wes_pkg.sv
hdl/wes_ram.sv
hdl/wes_target.sv
hdl/weighted_event_selector_unit.sv
test/tb.sv
